// File: rtl/core/mexp_pkg.sv
package mexp_pkg;

  localparam int unsigned MOD_WIDTH_DEF = 32;
  localparam int unsigned EXP_WIDTH_DEF = 64;

  // Width of the remainder unit's dividend: covers the 64-bit base and any product.
  localparam int unsigned DVD_W = 64;
  localparam int unsigned RED_CNT_W = $clog2(DVD_W);

  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Program addresses.
  localparam step_t STEP_ACCEPT    = 4'd0;
  localparam step_t STEP_CHECK     = 4'd1;
  localparam step_t STEP_RED_BASE  = 4'd2;
  localparam step_t STEP_SET_BM    = 4'd3;
  localparam step_t STEP_SQR       = 4'd4;
  localparam step_t STEP_RED_SQR   = 4'd5;
  localparam step_t STEP_ST_SQR    = 4'd6;
  localparam step_t STEP_MUL       = 4'd7;
  localparam step_t STEP_RED_MUL   = 4'd8;
  localparam step_t STEP_ST_MUL    = 4'd9;
  localparam step_t STEP_TEST_IDX  = 4'd10;
  localparam step_t STEP_SHIFT_E   = 4'd11;
  localparam step_t STEP_EMIT      = 4'd12;
  localparam step_t STEP_EMIT_WAIT = 4'd13;
  localparam step_t STEP_BAD       = 4'd14;
  localparam step_t STEP_BAD_WAIT  = 4'd15;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_RED,
    OP_SET_BM,
    OP_SQR,
    OP_MUL,
    OP_ST_ACC,
    OP_SHIFT_E,
    OP_EMIT,
    OP_EMIT_BAD
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_MOD_ZERO,
    COND_RED_MORE,
    COND_BIT_ZERO,
    COND_IDX_ZERO,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctl_word_t;

  typedef struct packed {
    logic req_valid;
    logic mod_zero;
    logic red_more;
    logic bit_zero;
    logic idx_zero;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] exponent;
    logic [31:0] modulus;
  } req_t;

  typedef struct packed {
    logic [31:0] power_mod;
    logic        bad_modulus;
  } rsp_t;

endpackage

// File: rtl/core/modular_exponentiation_lr.sv
// Modular exponentiation, left to right: rsp.power_mod = base ** exponent mod modulus.
// A request on the req channel carries base, exponent and modulus; the answer comes
// back on the rsp channel, one response per request, in order. Only the low
// MOD_WIDTH bits of the modulus and the low EXP_WIDTH bits of the exponent count.
// One request is worked on at a time; req_stall is low only while the control
// program sits at its accept step. For a zero modulus, rsp_valid rises with
// bad_modulus set and a power_mod of zero. Otherwise the base is reduced, then
// each exponent bit, most significant first, squares the accumulator and, if
// set, multiplies it by the reduced base. Every reduction goes through the
// remainder unit, which retires one dividend bit per cycle and works through
// all 64 dividend bits for each of the base reduction, every square and every
// multiply by the base.
// The response sits in an output register; rsp_valid holds while rsp_stall is
// high, and the program waits at its emit step until the register is free.
// Reset returns the program to the accept step and drops rsp_valid.
module modular_exponentiation_lr #(
  parameter int unsigned MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
  parameter int unsigned EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mexp_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mexp_pkg::rsp_t rsp
);

  mexp_pkg::step_t      step;
  mexp_pkg::ctl_word_t  word;
  mexp_pkg::dp_status_t status;

  mexp_rom u_rom (
    .step (step),
    .word (word)
  );

  mexp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .word   (word),
    .status (status),
    .step   (step)
  );

  mexp_dp #(
    .MOD_WIDTH (MOD_WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .word      (word),
    .status    (status),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: rtl/core/mexp_rom.sv
module mexp_rom (
  input  mexp_pkg::step_t     step,
  output mexp_pkg::ctl_word_t word
);

  always_comb begin
    word = '{op: mexp_pkg::OP_NOP, cond: mexp_pkg::COND_ALWAYS,
             target: mexp_pkg::STEP_ACCEPT};
    unique case (step)
      mexp_pkg::STEP_ACCEPT: begin
        word = '{op: mexp_pkg::OP_ACCEPT, cond: mexp_pkg::COND_NO_REQ,
                 target: mexp_pkg::STEP_ACCEPT};
      end
      mexp_pkg::STEP_CHECK: begin
        word = '{op: mexp_pkg::OP_NOP, cond: mexp_pkg::COND_MOD_ZERO,
                 target: mexp_pkg::STEP_BAD};
      end
      mexp_pkg::STEP_RED_BASE: begin
        word = '{op: mexp_pkg::OP_RED, cond: mexp_pkg::COND_RED_MORE,
                 target: mexp_pkg::STEP_RED_BASE};
      end
      mexp_pkg::STEP_SET_BM: begin
        word = '{op: mexp_pkg::OP_SET_BM, cond: mexp_pkg::COND_NEXT,
                 target: mexp_pkg::STEP_ACCEPT};
      end
      mexp_pkg::STEP_SQR: begin
        word = '{op: mexp_pkg::OP_SQR, cond: mexp_pkg::COND_NEXT,
                 target: mexp_pkg::STEP_ACCEPT};
      end
      mexp_pkg::STEP_RED_SQR: begin
        word = '{op: mexp_pkg::OP_RED, cond: mexp_pkg::COND_RED_MORE,
                 target: mexp_pkg::STEP_RED_SQR};
      end
      mexp_pkg::STEP_ST_SQR: begin
        word = '{op: mexp_pkg::OP_ST_ACC, cond: mexp_pkg::COND_BIT_ZERO,
                 target: mexp_pkg::STEP_TEST_IDX};
      end
      mexp_pkg::STEP_MUL: begin
        word = '{op: mexp_pkg::OP_MUL, cond: mexp_pkg::COND_NEXT,
                 target: mexp_pkg::STEP_ACCEPT};
      end
      mexp_pkg::STEP_RED_MUL: begin
        word = '{op: mexp_pkg::OP_RED, cond: mexp_pkg::COND_RED_MORE,
                 target: mexp_pkg::STEP_RED_MUL};
      end
      mexp_pkg::STEP_ST_MUL: begin
        word = '{op: mexp_pkg::OP_ST_ACC, cond: mexp_pkg::COND_NEXT,
                 target: mexp_pkg::STEP_ACCEPT};
      end
      mexp_pkg::STEP_TEST_IDX: begin
        word = '{op: mexp_pkg::OP_NOP, cond: mexp_pkg::COND_IDX_ZERO,
                 target: mexp_pkg::STEP_EMIT};
      end
      mexp_pkg::STEP_SHIFT_E: begin
        word = '{op: mexp_pkg::OP_SHIFT_E, cond: mexp_pkg::COND_ALWAYS,
                 target: mexp_pkg::STEP_SQR};
      end
      mexp_pkg::STEP_EMIT: begin
        word = '{op: mexp_pkg::OP_EMIT, cond: mexp_pkg::COND_OUT_FREE,
                 target: mexp_pkg::STEP_ACCEPT};
      end
      mexp_pkg::STEP_EMIT_WAIT: begin
        word = '{op: mexp_pkg::OP_NOP, cond: mexp_pkg::COND_ALWAYS,
                 target: mexp_pkg::STEP_EMIT};
      end
      mexp_pkg::STEP_BAD: begin
        word = '{op: mexp_pkg::OP_EMIT_BAD, cond: mexp_pkg::COND_OUT_FREE,
                 target: mexp_pkg::STEP_ACCEPT};
      end
      mexp_pkg::STEP_BAD_WAIT: begin
        word = '{op: mexp_pkg::OP_NOP, cond: mexp_pkg::COND_ALWAYS,
                 target: mexp_pkg::STEP_BAD};
      end
      default: begin
        word = '{op: mexp_pkg::OP_NOP, cond: mexp_pkg::COND_ALWAYS,
                 target: mexp_pkg::STEP_ACCEPT};
      end
    endcase
  end

endmodule

// File: rtl/core/mexp_seq.sv
module mexp_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  mexp_pkg::ctl_word_t  word,
  input  mexp_pkg::dp_status_t status,
  output mexp_pkg::step_t      step
);

  logic jump;

  always_comb begin
    jump = 1'b0;
    unique case (word.cond)
      mexp_pkg::COND_NEXT:     jump = 1'b0;
      mexp_pkg::COND_ALWAYS:   jump = 1'b1;
      mexp_pkg::COND_NO_REQ:   jump = !status.req_valid;
      mexp_pkg::COND_MOD_ZERO: jump = status.mod_zero;
      mexp_pkg::COND_RED_MORE: jump = status.red_more;
      mexp_pkg::COND_BIT_ZERO: jump = status.bit_zero;
      mexp_pkg::COND_IDX_ZERO: jump = status.idx_zero;
      mexp_pkg::COND_OUT_FREE: jump = status.out_free;
      default:                 jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= mexp_pkg::STEP_ACCEPT;
    end else if (jump) begin
      step <= word.target;
    end else begin
      step <= step + mexp_pkg::step_t'(1);
    end
  end

endmodule

// File: rtl/core/mexp_dp.sv
module mexp_dp #(
  parameter int unsigned MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
  parameter int unsigned EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mexp_pkg::ctl_word_t  word,
  output mexp_pkg::dp_status_t status,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  mexp_pkg::req_t       req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output mexp_pkg::rsp_t       rsp
);

  localparam int unsigned IDX_W = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;
  localparam int unsigned PROD_W = 2 * MOD_WIDTH;
  localparam int unsigned DVD_W = mexp_pkg::DVD_W;
  localparam int unsigned CNT_W = mexp_pkg::RED_CNT_W;

  logic [MOD_WIDTH-1:0] m;
  logic [EXP_WIDTH-1:0] e;
  logic [IDX_W-1:0]     idx;
  logic [MOD_WIDTH-1:0] bm;
  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] rem;
  logic [DVD_W-1:0]     dvd;
  logic [CNT_W-1:0]     cnt;

  logic [MOD_WIDTH-1:0] opnd;
  logic [PROD_W-1:0]    prod;
  logic [MOD_WIDTH:0]   shifted;
  logic [MOD_WIDTH:0]   diff;
  logic [MOD_WIDTH-1:0] rem_next;
  logic                 out_free;
  logic                 accept;

  assign accept    = req_valid && (word.op == mexp_pkg::OP_ACCEPT);
  assign req_stall = (word.op != mexp_pkg::OP_ACCEPT);
  assign out_free  = !(rsp_valid && rsp_stall);

  // One multiplier serves both the square and the multiply by the reduced base.
  assign opnd = (word.op == mexp_pkg::OP_MUL) ? bm : acc;
  assign prod = PROD_W'(acc) * PROD_W'(opnd);

  // Restoring remainder step: the partial remainder stays below m, so the
  // shifted value stays below 2m and one conditional subtract suffices.
  assign shifted  = {rem, dvd[DVD_W-1]};
  assign diff     = shifted - {1'b0, m};
  assign rem_next = (shifted >= {1'b0, m}) ? diff[MOD_WIDTH-1:0] : shifted[MOD_WIDTH-1:0];

  assign status.req_valid = req_valid;
  assign status.mod_zero  = (m == '0);
  assign status.red_more  = (cnt != CNT_W'(DVD_W - 1));
  assign status.bit_zero  = !e[EXP_WIDTH-1];
  assign status.idx_zero  = (idx == '0);
  assign status.out_free  = out_free;

  always_ff @(posedge clk) begin
    unique case (word.op)
      mexp_pkg::OP_ACCEPT: begin
        if (accept) begin
          m   <= req.modulus[MOD_WIDTH-1:0];
          e   <= req.exponent[EXP_WIDTH-1:0];
          dvd <= req.base;
          rem <= '0;
          cnt <= '0;
        end
      end
      mexp_pkg::OP_RED: begin
        rem <= rem_next;
        dvd <= dvd << 1;
        cnt <= cnt + CNT_W'(1);
      end
      mexp_pkg::OP_SET_BM: begin
        bm  <= rem;
        acc <= (m == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
        idx <= IDX_W'(EXP_WIDTH - 1);
      end
      mexp_pkg::OP_SQR, mexp_pkg::OP_MUL: begin
        dvd <= DVD_W'(prod);
        rem <= '0;
        cnt <= '0;
      end
      mexp_pkg::OP_ST_ACC: begin
        acc <= rem;
      end
      mexp_pkg::OP_SHIFT_E: begin
        e   <= e << 1;
        idx <= idx - IDX_W'(1);
      end
      mexp_pkg::OP_EMIT: begin
        if (out_free) begin
          rsp.power_mod   <= 32'(acc);
          rsp.bad_modulus <= 1'b0;
        end
      end
      mexp_pkg::OP_EMIT_BAD: begin
        if (out_free) begin
          rsp.power_mod   <= '0;
          rsp.bad_modulus <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free && (word.op == mexp_pkg::OP_EMIT ||
                              word.op == mexp_pkg::OP_EMIT_BAD)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule
